// ----- hw/rtl/ordq_pkg.sv -----
package ordq_pkg;

	localparam int DEPTH     = 16;
	localparam int KEY_BYTES = 7;

	localparam int KEY_W    = 56;
	localparam int KIND_W   = 2;
	localparam int STATUS_W = 3;
	localparam int POS_W    = 4;
	localparam int COUNT_W  = 5;

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	localparam int CMP_BYTES = (KEY_BYTES < KEY_W / 8) ? KEY_BYTES : KEY_W / 8;
	localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} >> (KEY_W - 8 * CMP_BYTES);

	typedef logic [KEY_W-1:0] key_t;
	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_APPEND = 2'd0,
		KIND_DELETE = 2'd1,
		KIND_DUMP   = 2'd2
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_INSERTED   = 3'd0,
		STS_FULL       = 3'd1,
		STS_DELETED    = 3'd2,
		STS_NOT_FOUND  = 3'd3,
		STS_DUMP_ENTRY = 3'd4,
		STS_DUMP_EMPTY = 3'd5
	} status_t;

	typedef struct packed {
		logic we;
		idx_t waddr;
		key_t wdata;
		logic re;
		idx_t raddr;
	} mem_req_t;

	function automatic logic [POS_W-1:0] to_pos(input idx_t idx);
		logic [31:0] wide;
		wide = 32'(idx);
		return wide[POS_W-1:0];
	endfunction

	function automatic logic [COUNT_W-1:0] to_count(input cnt_t cnt);
		logic [31:0] wide;
		wide = 32'(cnt);
		return wide[COUNT_W-1:0];
	endfunction

endpackage

// ----- hw/rtl/ordq_keycmp.sv -----
module ordq_keycmp (
	input  ordq_pkg::key_t a,
	input  ordq_pkg::key_t b,
	output logic           eq
);
	import ordq_pkg::*;

	always_comb begin
		logic done;
		logic eq_v;
		done = 1'b0;
		eq_v = 1'b1;
		// string compare, stops at the first zero byte
		for (int i = 0; i < CMP_BYTES; i++) begin
			if (!done) begin
				if (a[8*i +: 8] != b[8*i +: 8]) begin
					eq_v = 1'b0;
					done = 1'b1;
				end else if (a[8*i +: 8] == 8'd0) begin
					done = 1'b1;
				end
			end
		end
		eq = eq_v;
	end

endmodule

// ----- hw/rtl/ordq_store.sv -----
module ordq_store (
	input  logic               clk,
	input  ordq_pkg::mem_req_t req,
	output ordq_pkg::key_t     rdata
);
	import ordq_pkg::*;

	key_t mem_q [DEPTH];
	key_t rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem_q[req.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- hw/rtl/ordered_queue_delete_by_key_core.sv -----
// append: S_APPEND writes the key, S_REPORT the result; new beats only taken in idle
// delete: S_SCAN_RD/S_SCAN_CMP per entry scanned, S_SHIFT_RD/S_SHIFT_WR per entry
// moved up; one key compare and one key store (a read and a write port) set the pace
// dump: S_DUMP_RD then S_DUMP_EMIT per result beat, one store read per entry
// reset clears the entry count (queue empty); stored keys are left as they are
module ordered_queue_delete_by_key_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [ordq_pkg::KIND_W-1:0]     kind,
	input  ordq_pkg::key_t                  key,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [ordq_pkg::STATUS_W-1:0]   status,
	output ordq_pkg::key_t                  entry_key,
	output logic [ordq_pkg::POS_W-1:0]      position,
	output logic [ordq_pkg::COUNT_W-1:0]    count,
	output logic                            last
);
	import ordq_pkg::*;

	typedef enum logic [8:0] {
		S_IDLE      = 9'b000000001,
		S_APPEND    = 9'b000000010,
		S_SCAN_RD   = 9'b000000100,
		S_SCAN_CMP  = 9'b000001000,
		S_SHIFT_RD  = 9'b000010000,
		S_SHIFT_WR  = 9'b000100000,
		S_DUMP_RD   = 9'b001000000,
		S_DUMP_EMIT = 9'b010000000,
		S_REPORT    = 9'b100000000
	} state_t;

	state_t   state_q;
	cnt_t     count_q;
	idx_t     idx_q;
	key_t     key_q;
	status_t  res_status_q;
	key_t     res_key_q;
	idx_t     res_pos_q;

	logic                  out_valid_q;
	status_t               out_status_q;
	key_t                  out_key_q;
	logic [POS_W-1:0]      out_pos_q;
	logic [COUNT_W-1:0]    out_count_q;
	logic                  out_last_q;

	mem_req_t mem_req;
	key_t     rdata;
	logic     key_eq;
	cnt_t     idx_next;
	logic     more;
	logic     out_free;

	ordq_store u_store (
		.clk   (clk),
		.req   (mem_req),
		.rdata (rdata)
	);

	ordq_keycmp u_keycmp (
		.a  (rdata),
		.b  (key_q),
		.eq (key_eq)
	);

	assign idx_next = CNT_W'(idx_q) + CNT_W'(1);
	assign more     = idx_next < count_q;
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		mem_req       = '0;
		mem_req.wdata = key_q;
		case (state_q)
			S_APPEND: begin
				mem_req.we    = (count_q != CNT_W'(DEPTH));
				mem_req.waddr = count_q[IDX_W-1:0];
			end
			S_SCAN_RD, S_DUMP_RD: begin
				mem_req.re    = 1'b1;
				mem_req.raddr = idx_q;
			end
			S_SHIFT_RD: begin
				mem_req.re    = more;
				mem_req.raddr = idx_next[IDX_W-1:0];
			end
			S_SHIFT_WR: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = idx_q;
				mem_req.wdata = rdata;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						case (kind_t'(kind))
							KIND_APPEND: state_q <= S_APPEND;
							KIND_DELETE: state_q <= (count_q == '0) ? S_REPORT : S_SCAN_RD;
							KIND_DUMP:   state_q <= (count_q == '0) ? S_REPORT : S_DUMP_RD;
							default:     state_q <= S_IDLE;
						endcase
					end
				end
				S_APPEND: begin
					if (count_q != CNT_W'(DEPTH)) begin
						count_q <= count_q + CNT_W'(1);
					end
					state_q <= S_REPORT;
				end
				S_SCAN_RD: begin
					state_q <= S_SCAN_CMP;
				end
				S_SCAN_CMP: begin
					if (key_eq) begin
						state_q <= S_SHIFT_RD;
					end else if (more) begin
						state_q <= S_SCAN_RD;
					end else begin
						state_q <= S_REPORT;
					end
				end
				S_SHIFT_RD: begin
					if (more) begin
						state_q <= S_SHIFT_WR;
					end else begin
						count_q <= count_q - CNT_W'(1);
						state_q <= S_REPORT;
					end
				end
				S_SHIFT_WR: begin
					state_q <= S_SHIFT_RD;
				end
				S_DUMP_RD: begin
					state_q <= S_DUMP_EMIT;
				end
				S_DUMP_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= more ? S_DUMP_RD : S_IDLE;
					end
				end
				S_REPORT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				idx_q     <= '0;
				key_q     <= key & KEY_MASK;
				res_key_q <= '0;
				res_pos_q <= '0;
				case (kind_t'(kind))
					KIND_DELETE: res_status_q <= STS_NOT_FOUND;
					KIND_DUMP:   res_status_q <= STS_DUMP_EMPTY;
					default:     res_status_q <= STS_INSERTED;
				endcase
			end
			S_APPEND: begin
				res_status_q <= (count_q != CNT_W'(DEPTH)) ? STS_INSERTED : STS_FULL;
			end
			S_SCAN_CMP: begin
				if (key_eq) begin
					res_key_q    <= rdata;
					res_pos_q    <= idx_q;
					res_status_q <= STS_DELETED;
				end else if (more) begin
					idx_q <= idx_next[IDX_W-1:0];
				end
			end
			S_SHIFT_WR: begin
				idx_q <= idx_next[IDX_W-1:0];
			end
			S_DUMP_EMIT: begin
				if (out_free) begin
					out_status_q <= STS_DUMP_ENTRY;
					out_key_q    <= rdata;
					out_pos_q    <= to_pos(idx_q);
					out_count_q  <= to_count(count_q);
					out_last_q   <= !more;
					if (more) begin
						idx_q <= idx_next[IDX_W-1:0];
					end
				end
			end
			S_REPORT: begin
				if (out_free) begin
					out_status_q <= res_status_q;
					out_key_q    <= res_key_q;
					out_pos_q    <= to_pos(res_pos_q);
					out_count_q  <= to_count(count_q);
					out_last_q   <= 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign status    = out_status_q;
	assign entry_key = out_key_q;
	assign position  = out_pos_q;
	assign count     = out_count_q;
	assign last      = out_last_q;

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

module tb;
	import ordq_pkg::*;

	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam int ITEMS_PER_PHASE = 25;
	localparam int HOLD_CYCLES     = 300;
	localparam int DRAIN_CYCLES    = 200;
	localparam int CYCLE_LIMIT     = 400000;

	localparam key_t KEY_ONES    = {KEY_W{1'b1}};
	localparam key_t KEY_AB_XYZ  = 56'h00_7A_79_78_00_62_61;
	localparam key_t KEY_AB_QQ   = 56'h00_51_51_00_62_61;
	localparam key_t KEY_ABC     = 56'h63_62_61;
	localparam key_t KEY_FULL7   = 56'h47_46_45_44_43_42_41;
	localparam key_t KEY_ZZ      = 56'h7A_7A;

	typedef struct packed {
		status_t             st;
		key_t                ekey;
		logic [POS_W-1:0]    pos;
		logic [COUNT_W-1:0]  cnt;
		logic                lst;
	} beat_t;

	typedef struct packed {
		logic [KIND_W-1:0]  k;
		key_t               kk;
		logic [4:0]         reps;
		logic               typed;
		beat_t              want;
	} stim_row_t;

	localparam int N_ROWS = 17;

	stim_row_t directed_rows [N_ROWS] = '{
		'{KIND_DUMP,   '0,         5'd1,  1'b1, '{STS_DUMP_EMPTY, '0, '0, 5'd0, 1'b1}},
		'{KIND_DELETE, 56'h41,     5'd1,  1'b1, '{STS_NOT_FOUND, '0, '0, 5'd0, 1'b1}},
		'{KIND_APPEND, KEY_ONES,   5'd1,  1'b1, '{STS_INSERTED, '0, '0, 5'd1, 1'b1}},
		'{KIND_APPEND, '0,         5'd1,  1'b1, '{STS_INSERTED, '0, '0, 5'd2, 1'b1}},
		'{KIND_APPEND, KEY_AB_XYZ, 5'd1,  1'b1, '{STS_INSERTED, '0, '0, 5'd3, 1'b1}},
		'{KIND_APPEND, KEY_FULL7,  5'd1,  1'b1, '{STS_INSERTED, '0, '0, 5'd4, 1'b1}},
		'{KIND_UNUSED, KEY_ONES,   5'd1,  1'b0, '0},
		'{KIND_DELETE, KEY_ABC,    5'd1,  1'b1, '{STS_NOT_FOUND, '0, '0, 5'd4, 1'b1}},
		'{KIND_DELETE, KEY_AB_QQ,  5'd1,  1'b0, '0},
		'{KIND_DUMP,   '0,         5'd1,  1'b0, '0},
		'{KIND_DELETE, '0,         5'd1,  1'b0, '0},
		'{KIND_APPEND, KEY_FULL7,  5'd14, 1'b0, '0},
		'{KIND_APPEND, '0,         5'd1,  1'b1, '{STS_FULL, '0, '0, 5'd16, 1'b1}},
		'{KIND_DUMP,   '0,         5'd1,  1'b0, '0},
		'{KIND_DELETE, KEY_FULL7,  5'd1,  1'b0, '0},
		'{KIND_APPEND, KEY_ZZ,     5'd1,  1'b0, '0},
		'{KIND_DELETE, KEY_ZZ,     5'd1,  1'b0, '0}
	};

	int send_pcts [4] = '{0, 65, 0, 9};
	int stall_pcts [4] = '{0, 0, 65, 9};

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_ready;
	logic [KIND_W-1:0]      kind = '0;
	key_t                   key = '0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic [STATUS_W-1:0]    status;
	key_t                   entry_key;
	logic [POS_W-1:0]       position;
	logic [COUNT_W-1:0]     count;
	logic                   last;

	key_t   held_keys [$];
	beat_t  pending_beats [$];
	int     errors = 0;
	int     cycles = 0;
	int     beats_in = 0;
	int     beats_out = 0;
	int     status_seen [6] = '{0, 0, 0, 0, 0, 0};
	int     send_idle_pct = 0;
	int     recv_stall_pct = 0;
	int     hold_seq = 0;
	int     hold_seen = 0;
	int     hold_left = 0;

	ordered_queue_delete_by_key_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.key(key),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.entry_key(entry_key),
		.position(position),
		.count(count),
		.last(last)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic bit keys_match_as_strings(input key_t a, input key_t b);
		for (int i = 0; i < CMP_BYTES; i++) begin
			if (a[8*i +: 8] != b[8*i +: 8])
				return 1'b0;
			if (a[8*i +: 8] == 8'h00)
				return 1'b1;
		end
		return 1'b1;
	endfunction

	function automatic beat_t make_beat(input status_t st, input key_t ekey, input int pos,
			input int cnt, input logic lst);
		beat_t b;
		b.st = st;
		b.ekey = ekey;
		b.pos = POS_W'(pos);
		b.cnt = COUNT_W'(cnt);
		b.lst = lst;
		return b;
	endfunction

	function automatic void run_queue_op(input logic [KIND_W-1:0] k, input key_t kk);
		key_t masked;
		key_t found;
		int hit;
		masked = kk & KEY_MASK;
		hit = -1;
		case (k)
			KIND_APPEND: begin
				if (held_keys.size() >= DEPTH) begin
					pending_beats.push_back(make_beat(STS_FULL, '0, 0, held_keys.size(), 1'b1));
				end else begin
					held_keys.push_back(masked);
					pending_beats.push_back(make_beat(STS_INSERTED, '0, 0, held_keys.size(),
						1'b1));
				end
			end
			KIND_DELETE: begin
				for (int i = 0; i < held_keys.size(); i++)
					if (hit < 0 && keys_match_as_strings(held_keys[i], masked))
						hit = i;
				if (hit >= 0) begin
					found = held_keys[hit];
					held_keys.delete(hit);
					pending_beats.push_back(make_beat(STS_DELETED, found, hit, held_keys.size(),
						1'b1));
				end else begin
					pending_beats.push_back(make_beat(STS_NOT_FOUND, '0, 0, held_keys.size(),
						1'b1));
				end
			end
			KIND_DUMP: begin
				if (held_keys.size() == 0) begin
					pending_beats.push_back(make_beat(STS_DUMP_EMPTY, '0, 0, 0, 1'b1));
				end else begin
					for (int i = 0; i < held_keys.size(); i++)
						pending_beats.push_back(make_beat(STS_DUMP_ENTRY, held_keys[i], i,
							held_keys.size(), i == held_keys.size() - 1));
				end
			end
			default: ;
		endcase
	endfunction

	// randomize the bytes above the terminating zero, which a compare ignores
	function automatic key_t scramble_tail(input key_t kk);
		key_t r;
		int z;
		r = kk;
		z = -1;
		for (int i = 0; i < CMP_BYTES; i++)
			if (z < 0 && r[8*i +: 8] == 8'h00)
				z = i;
		if (z >= 0)
			for (int i = z + 1; i < KEY_W / 8; i++)
				r[8*i +: 8] = 8'($urandom_range(255));
		return r;
	endfunction

	function automatic key_t random_key();
		key_t r;
		int len;
		r = '0;
		len = ($urandom_range(3) == 0) ? $urandom_range(CMP_BYTES) : $urandom_range(2);
		for (int i = 0; i < len; i++)
			r[8*i +: 8] = 8'(8'h61 + $urandom_range(2));
		if ($urandom_range(1))
			r = scramble_tail(r);
		if ($urandom_range(9) == 0)
			r = key_t'({$urandom, $urandom});
		return r;
	endfunction

	task automatic pick_item(output logic [KIND_W-1:0] k, output key_t kk);
		int roll;
		int append_pct;
		roll = $urandom_range(99);
		append_pct = (held_keys.size() < 12) ? 50 : 35;
		kk = random_key();
		if (roll < 3)
			k = KIND_UNUSED;
		else if (roll < 3 + append_pct)
			k = KIND_APPEND;
		else if (roll < 90)
			k = KIND_DELETE;
		else
			k = KIND_DUMP;
		if (k == KIND_DELETE && held_keys.size() > 0 && $urandom_range(9) < 6)
			kk = scramble_tail(held_keys[$urandom_range(held_keys.size() - 1)]);
	endtask

	task automatic send_item(input logic [KIND_W-1:0] k, input key_t kk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		key <= kk;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		beats_in++;
		run_queue_op(k, kk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_beats.size() != 0);
	endtask

	function automatic void check_field(input string name, input logic [63:0] want_v,
			input logic [63:0] got_v);
		if (want_v !== got_v) begin
			$display("%0t: %s expected %h actual %h", $time, name, want_v, got_v);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else if (hold_seen != hold_seq) begin
			hold_seen = hold_seq;
			hold_left = HOLD_CYCLES;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		beat_t want;
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $time, cycles);
			$display("ordered_queue_delete_by_key_core: mismatch");
			$finish;
		end else if (arst_n && out_valid && out_ready) begin
			beats_out++;
			if (status < 6)
				status_seen[status]++;
			if (pending_beats.size() == 0) begin
				$display("%0t: unexpected beat, expected none actual status %0d", $time, status);
				errors++;
			end else begin
				want = pending_beats.pop_front();
				check_field("status", 64'(want.st), 64'(status));
				check_field("entry_key", 64'(want.ekey), 64'(entry_key));
				check_field("position", 64'(want.pos), 64'(position));
				check_field("count", 64'(want.cnt), 64'(count));
				check_field("last", 64'(want.lst), 64'(last));
			end
		end
	end

	initial begin
		logic [KIND_W-1:0] k;
		key_t kk;
		int done;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < N_ROWS; r++) begin
			for (int n = 0; n < directed_rows[r].reps; n++) begin
				send_item(directed_rows[r].k, directed_rows[r].kk);
				if (directed_rows[r].typed)
					pending_beats[pending_beats.size() - 1] = directed_rows[r].want;
			end
		end
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = send_pcts[ph];
			recv_stall_pct = stall_pcts[ph];
			if (ph == 0)
				hold_seq++;
			done = 0;
			while (done < ITEMS_PER_PHASE) begin
				pick_item(k, kk);
				send_item(k, kk);
				if (k != KIND_UNUSED)
					done++;
			end
			drain();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d input beats and %0d result beats over four idling phases",
			beats_in, beats_out);
		$display("statuses: inserted %0d, full %0d, deleted %0d, not found %0d, dump %0d, empty %0d",
			status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4],
			status_seen[5]);
		if (errors == 0)
			$display("ordered_queue_delete_by_key_core: match");
		else
			$display("ordered_queue_delete_by_key_core: mismatch");
		$finish;
	end

endmodule
